### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/dlnn_pkg.sv
// Types and constants shared by the local surface normal block.
`timescale 1ns / 1ps

package dlnn_pkg;

  localparam int COORD_W    = 40;
  localparam int NORMAL_W   = 32;
  localparam int FRAC_W     = NORMAL_W - 2;
  localparam int QUOT_W     = NORMAL_W - 1;
  localparam int MAG_W      = 64;
  localparam int HALF_W     = 32;
  localparam int ACC_W      = 128;
  localparam int DIFF_SHIFT = (COORD_W > 62) ? (COORD_W - 62) : 0;

  localparam logic [2:0] SLOT_CENTER = 3'd4;

  // partial product placement in the accumulator
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_ONE  = 2'd1;
  localparam logic [1:0] SH_TWO  = 2'd2;

  // accumulator lane holding the sum of squares, then the dot product
  localparam logic [1:0] LANE_SUM = 2'd3;

  localparam logic signed [NORMAL_W-1:0] NORM_ONE = NORMAL_W'(1) <<< FRAC_W;

  typedef struct packed {
    logic [2:0]                point_slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      neighbors_present;
  } pt_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       normal_valid;
  } nrm_t;

  typedef struct packed {
    logic              vld;
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
    logic [1:0]        sh;
    logic              neg;
    logic              clr;
    logic [1:0]        dest;
  } mac_op_t;

endpackage

### rtl/dlnn_mac.sv
// Shared 32x32 multiplier with a registered signed 128-bit accumulator bank.
`timescale 1ns / 1ps

module dlnn_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dlnn_pkg::mac_op_t                     op,
  input  logic                                  wr_en,
  input  logic [2:0][dlnn_pkg::ACC_W-1:0]       wr_data,
  output logic [3:0][dlnn_pkg::ACC_W-1:0]       acc
);

  logic [2*dlnn_pkg::HALF_W-1:0] prod;
  logic                          p_vld;
  logic [1:0]                    p_sh;
  logic                          p_neg;
  logic                          p_clr;
  logic [1:0]                    p_dest;
  logic [dlnn_pkg::ACC_W-1:0]    term;
  logic [dlnn_pkg::ACC_W-1:0]    addend;
  logic [dlnn_pkg::ACC_W-1:0]    base;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= op.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= op.a * op.b;
    p_sh   <= op.sh;
    p_neg  <= op.neg;
    p_clr  <= op.clr;
    p_dest <= op.dest;
  end

  always_comb begin
    case (p_sh)
      dlnn_pkg::SH_ONE: term = dlnn_pkg::ACC_W'(prod) << dlnn_pkg::HALF_W;
      dlnn_pkg::SH_TWO: term = dlnn_pkg::ACC_W'(prod) << (2 * dlnn_pkg::HALF_W);
      default:          term = dlnn_pkg::ACC_W'(prod);
    endcase
    addend = p_neg ? (dlnn_pkg::ACC_W'(0) - term) : term;
    base   = p_clr ? dlnn_pkg::ACC_W'(0) : acc[p_dest];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc[0] <= wr_data[0];
      acc[1] <= wr_data[1];
      acc[2] <= wr_data[2];
    end else if (p_vld) begin
      acc[p_dest] <= base + addend;
    end
  end

endmodule

### rtl/dlnn_isqrt.sv
// Floor square root of a 64-bit value, two radicand bits per cycle.
`timescale 1ns / 1ps

module dlnn_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (cnt == 5'd31)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rad;
      res  <= 64'd0;
      bitv <= 64'd1 << 62;
      cnt  <= 5'd0;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

### rtl/dlnn_udiv.sv
// Restoring fractional divider: round(num * 2^FRAC_W / den) for num <= den.
`timescale 1ns / 1ps

module dlnn_udiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 num,
  input  logic [31:0]                 den,
  output logic                        done,
  output logic [dlnn_pkg::QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(dlnn_pkg::FRAC_W + 2);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(dlnn_pkg::FRAC_W + 1);

  logic [32:0]      r;
  logic [32:0]      rr;
  logic [32:0]      den_x;
  logic             qbit;
  logic             rnd;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign den_x = {1'b0, den};
  assign rr    = (cnt == '0) ? r : (r << 1);
  assign qbit  = (rr >= den_x);
  assign rnd   = ({r[31:0], 1'b0} >= den_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (cnt == LAST)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r    <= {1'b0, num};
      quot <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == LAST) begin
        // round half up on the remainder
        quot <= quot + dlnn_pkg::QUOT_W'(rnd);
      end else begin
        r    <= qbit ? (rr - den_x) : rr;
        quot <= {quot[dlnn_pkg::QUOT_W-2:0], qbit};
        cnt  <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

### rtl/dem_local_normal_from_neighbors_core.sv
// Top level: local surface normal from four neighbor points and a center point.
//
// Input channel pt (valid/ready, payload pt_t): slots top, bottom, left and right
// store a neighbor point and give no result. A center slot starts the
// computation; slot codes above center are dropped. pt_ready is high only while the
// sequencer is idle, so a center item blocks the input until its result is queued.
// Output channel nrm (valid/ready, payload nrm_t): one result per center item, held
// in an output register; a new item is taken while a result waits there.
// A center item runs the cross product on the shared 32x32 multiplier (24 partial
// products), normalization, the squares, then the outward dot product on the
// multiplier while the 32-step square root runs, then the FRAC_W+2 step dividers
// (three lanes in parallel). Without neighbors the sequencer goes from idle straight
// to its final state and loads the zero result into the output register.
// If the receiver stalls, the finished result stays in the output register and the
// sequencer waits in its final state until the register is free.
// Reset clears the sequencer and the output valid; stored neighbor points are not
// cleared and must be written before a center item uses them.
`timescale 1ns / 1ps

module dem_local_normal_from_neighbors_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            pt_valid,
  output logic            pt_ready,
  input  dlnn_pkg::pt_t   pt_data,
  output logic            nrm_valid,
  input  logic            nrm_ready,
  output dlnn_pkg::nrm_t  nrm_data
);

  localparam int CW = dlnn_pkg::COORD_W;
  localparam int MW = dlnn_pkg::MAG_W;
  localparam int HW = dlnn_pkg::HALF_W;
  localparam int AW = dlnn_pkg::ACC_W;
  localparam int NW = dlnn_pkg::NORMAL_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_CROSS = 4'd2;
  localparam logic [3:0] S_ABS   = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_DOT   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [4:0] CROSS_OPS = 5'd24;
  localparam logic [4:0] SQ_OPS    = 5'd3;
  localparam logic [4:0] DOT_OPS   = 5'd6;

  logic [3:0] state;
  logic [4:0] cnt;

  logic [CW-1:0]        nb [4][3];
  logic signed [CW-1:0] cen [3];

  logic signed [CW:0]   dtf [3];
  logic signed [CW:0]   drf [3];
  logic [MW-1:0]        dt64 [3];
  logic [MW-1:0]        dr64 [3];
  logic [MW-1:0]        c64 [3];
  logic [MW-1:0]        tmag [3];
  logic [MW-1:0]        rmag [3];
  logic [MW-1:0]        cmag [3];
  logic [2:0]           tsgn;
  logic [2:0]           rsgn;
  logic [2:0]           csgn;
  logic [2:0]           negs;
  logic                 nvalid;

  dlnn_pkg::mac_op_t    op;
  logic                 mac_wr;
  logic [2:0][AW-1:0]   wr_data;
  logic [3:0][AW-1:0]   acc;

  logic [AW-1:0]        orv;
  logic                 too_big;
  logic                 in_range;
  logic [2:0][AW-1:0]   abs_data;
  logic [2:0][AW-1:0]   norm_data;

  logic [1:0]           ai;
  logic [1:0]           bi;
  logic [1:0]           comp;
  logic [1:0]           dcomp;

  logic                 sq_start;
  logic                 sq_done;
  logic [31:0]          root;
  logic                 div_start;
  logic [2:0]           div_done;
  logic [dlnn_pkg::QUOT_W-1:0] quot [3];

  logic                 flip;
  logic [NW-1:0]        qx [3];
  logic [NW-1:0]        sv [3];
  logic                 out_load;
  logic                 pt_acc;

  assign pt_ready = (state == S_IDLE);
  assign pt_acc   = pt_valid && pt_ready;
  assign out_load = (state == S_DONE) && (!nrm_valid || nrm_ready);

  // operand preparation: neighbor differences and the center point, sign-extended to 64 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dtf[i]  = {nb[0][i][CW-1], nb[0][i]} - {nb[1][i][CW-1], nb[1][i]};
      drf[i]  = {nb[3][i][CW-1], nb[3][i]} - {nb[2][i][CW-1], nb[2][i]};
      dt64[i] = MW'(dtf[i] >>> dlnn_pkg::DIFF_SHIFT);
      dr64[i] = MW'(drf[i] >>> dlnn_pkg::DIFF_SHIFT);
      c64[i]  = MW'(cen[i]);
    end
  end

  // multiplier op sequencing
  assign comp  = cnt[4:3];
  assign dcomp = cnt[2:1];

  always_comb begin
    unique case (comp)
      2'd0:    begin ai = cnt[2] ? 2'd2 : 2'd1; bi = cnt[2] ? 2'd1 : 2'd2; end
      2'd1:    begin ai = cnt[2] ? 2'd0 : 2'd2; bi = cnt[2] ? 2'd2 : 2'd0; end
      2'd2:    begin ai = cnt[2] ? 2'd1 : 2'd0; bi = cnt[2] ? 2'd0 : 2'd1; end
      default: begin ai = 2'd0; bi = 2'd0; end
    endcase
  end

  always_comb begin
    op = '0;
    if ((state == S_CROSS) && (cnt < CROSS_OPS)) begin
      op.vld  = 1'b1;
      op.a    = cnt[1] ? tmag[ai][MW-1:HW] : tmag[ai][HW-1:0];
      op.b    = cnt[0] ? rmag[bi][MW-1:HW] : rmag[bi][HW-1:0];
      op.sh   = {cnt[1] & cnt[0], cnt[1] ^ cnt[0]};
      op.neg  = tsgn[ai] ^ rsgn[bi] ^ cnt[2];
      op.clr  = (cnt[2:0] == 3'd0);
      op.dest = comp;
    end else if ((state == S_SQ) && (cnt < SQ_OPS)) begin
      op.vld  = 1'b1;
      op.a    = {1'b0, acc[cnt[1:0]][30:0]};
      op.b    = {1'b0, acc[cnt[1:0]][30:0]};
      op.sh   = dlnn_pkg::SH_NONE;
      op.clr  = (cnt == 5'd0);
      op.dest = dlnn_pkg::LANE_SUM;
    end else if ((state == S_DOT) && (cnt < DOT_OPS)) begin
      op.vld  = 1'b1;
      op.a    = {1'b0, acc[dcomp][30:0]};
      op.b    = cnt[0] ? cmag[dcomp][MW-1:HW] : cmag[dcomp][HW-1:0];
      op.sh   = cnt[0] ? dlnn_pkg::SH_ONE : dlnn_pkg::SH_NONE;
      op.neg  = negs[dcomp] ^ csgn[dcomp];
      op.clr  = (cnt == 5'd0);
      op.dest = dlnn_pkg::LANE_SUM;
    end
  end

  // abs and normalization of the cross vector; largest component ends in [2^30, 2^31)
  assign orv      = acc[0] | acc[1] | acc[2];
  assign too_big  = |orv[AW-1:31];
  assign in_range = !too_big && orv[30];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_data[i] = acc[i][AW-1] ? (AW'(0) - acc[i]) : acc[i];
      if (too_big) begin
        if (|orv[AW-1:62])      norm_data[i] = acc[i] >> 32;
        else if (|orv[AW-1:34]) norm_data[i] = acc[i] >> 4;
        else                    norm_data[i] = acc[i] >> 1;
      end else begin
        if (~|orv[AW-1:14])      norm_data[i] = acc[i] << 16;
        else if (~|orv[AW-1:26]) norm_data[i] = acc[i] << 4;
        else                     norm_data[i] = acc[i] << 1;
      end
    end
  end

  always_comb begin
    mac_wr  = 1'b0;
    wr_data = norm_data;
    if (state == S_ABS) begin
      mac_wr  = 1'b1;
      wr_data = abs_data;
    end else if ((state == S_NORM) && (orv != '0) && !in_range) begin
      mac_wr = 1'b1;
    end
  end

  dlnn_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .wr_en   (mac_wr),
    .wr_data (wr_data),
    .acc     (acc)
  );

  // the sum of squares is final in the first dot cycle
  assign sq_start  = (state == S_DOT) && (cnt == 5'd0);
  assign div_start = (state == S_SQRT) && sq_done;

  dlnn_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (acc[dlnn_pkg::LANE_SUM][63:0]),
    .done  (sq_done),
    .root  (root)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    dlnn_udiv u_udiv (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   ({1'b0, acc[g][30:0]}),
      .den   (root),
      .done  (div_done[g]),
      .quot  (quot[g])
    );
  end

  // result assembly; a negative dot product flips the normal outward
  assign flip = acc[dlnn_pkg::LANE_SUM][AW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i] = NW'(quot[i]);
      sv[i] = (negs[i] ^ flip) ? (NW'(0) - qx[i]) : qx[i];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 5'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pt_acc && (pt_data.point_slot == dlnn_pkg::SLOT_CENTER)) begin
            state <= pt_data.neighbors_present ? S_DIFF : S_DONE;
          end
        end
        S_DIFF: begin
          cnt   <= 5'd0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // a final step with no op lets the last partial product land
          if (cnt == CROSS_OPS) state <= S_ABS;
          else                  cnt   <= cnt + 5'd1;
        end
        S_ABS: state <= S_NORM;
        S_NORM: begin
          if (orv == '0) begin
            state <= S_DONE;
          end else if (in_range) begin
            cnt   <= 5'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt == SQ_OPS) begin
            cnt   <= 5'd0;
            state <= S_DOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_DOT: begin
          if (cnt == DOT_OPS) state <= S_SQRT;
          else                cnt   <= cnt + 5'd1;
        end
        S_SQRT: if (sq_done) state <= S_DIV;
        S_DIV:  if (&div_done) state <= S_DONE;
        S_DONE: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pt_acc && !pt_data.point_slot[2]) begin
      nb[pt_data.point_slot[1:0]][0] <= pt_data.coord_x;
      nb[pt_data.point_slot[1:0]][1] <= pt_data.coord_y;
      nb[pt_data.point_slot[1:0]][2] <= pt_data.coord_z;
    end
    if (pt_acc && (pt_data.point_slot == dlnn_pkg::SLOT_CENTER)) begin
      cen[0] <= pt_data.coord_x;
      cen[1] <= pt_data.coord_y;
      cen[2] <= pt_data.coord_z;
      nvalid <= pt_data.neighbors_present;
    end
    if (state == S_DIFF) begin
      for (int i = 0; i < 3; i++) begin
        tmag[i] <= dt64[i][MW-1] ? (MW'(0) - dt64[i]) : dt64[i];
        rmag[i] <= dr64[i][MW-1] ? (MW'(0) - dr64[i]) : dr64[i];
        cmag[i] <= c64[i][MW-1] ? (MW'(0) - c64[i]) : c64[i];
        tsgn[i] <= dt64[i][MW-1];
        rsgn[i] <= dr64[i][MW-1];
        csgn[i] <= c64[i][MW-1];
      end
    end
    if (state == S_ABS) begin
      for (int i = 0; i < 3; i++) negs[i] <= acc[i][AW-1];
    end
    if ((state == S_NORM) && (orv == '0)) nvalid <= 1'b0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_valid <= 1'b0;
    end else if (out_load) begin
      nrm_valid <= 1'b1;
    end else if (nrm_ready) begin
      nrm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      nrm_data.normal_x     <= nvalid ? sv[0] : '0;
      nrm_data.normal_y     <= nvalid ? sv[1] : '0;
      nrm_data.normal_z     <= nvalid ? sv[2] : '0;
      nrm_data.normal_valid <= nvalid;
    end
  end

endmodule

### rtl/dlnn_checker.sv
// Port-level checks for the local surface normal block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dlnn_port_checks (
  input logic           clk,
  input logic           rst,
  input logic           pt_valid,
  input logic           pt_ready,
  input dlnn_pkg::pt_t  pt_data,
  input logic           nrm_valid,
  input logic           nrm_ready,
  input dlnn_pkg::nrm_t nrm_data
);

  logic ctr_take;
  logic nb_take;
  logic bad_zero;
  logic good_nrm;
  logic zero_vec;
  logic x_ok;
  logic y_ok;
  logic z_ok;
  logic out_stall;

  assign ctr_take = pt_valid && pt_ready && (pt_data.point_slot == dlnn_pkg::SLOT_CENTER);
  assign nb_take  = pt_valid && pt_ready && (pt_data.point_slot != dlnn_pkg::SLOT_CENTER);
  assign bad_zero = nrm_valid && !nrm_data.normal_valid;
  assign good_nrm = nrm_valid && nrm_data.normal_valid;
  assign zero_vec = (nrm_data.normal_x == '0) && (nrm_data.normal_y == '0) &&
                    (nrm_data.normal_z == '0);
  assign x_ok = (nrm_data.normal_x <= dlnn_pkg::NORM_ONE) &&
                (nrm_data.normal_x >= -dlnn_pkg::NORM_ONE);
  assign y_ok = (nrm_data.normal_y <= dlnn_pkg::NORM_ONE) &&
                (nrm_data.normal_y >= -dlnn_pkg::NORM_ONE);
  assign z_ok = (nrm_data.normal_z <= dlnn_pkg::NORM_ONE) &&
                (nrm_data.normal_z >= -dlnn_pkg::NORM_ONE);
  assign out_stall = nrm_valid && !nrm_ready;

  // an invalid normal carries a zero vector
  `ASSERT_IMPL(a_zero_when_invalid, clk, rst, bad_zero, zero_vec)

  // a valid normal stays within unit magnitude per component
  `ASSERT_IMPL(a_unit_bound, clk, rst, good_nrm, x_ok && y_ok && z_ok)

  // a center transaction occupies the sequencer
  `ASSERT_NEXT(a_center_busy, clk, rst, ctr_take, !pt_ready)

  // neighbor transactions leave the input ready in the next cycle
  `ASSERT_NEXT(a_neighbor_fast, clk, rst, nb_take, pt_ready)

  // a stalled result stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, nrm_valid && $stable(nrm_data))

endmodule

bind dem_local_normal_from_neighbors_core dlnn_port_checks u_dlnn_port_checks (.*);
